>>> sv/double_hash_open_address_table_defines.svh
// assertion macros shared by the hash table checker
`ifndef DOUBLE_HASH_OPEN_ADDRESS_TABLE_DEFINES_SVH
`define DOUBLE_HASH_OPEN_ADDRESS_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DHTAB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define DHTAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dhtab_pkg.sv
// shared types, codes and constants of the double hash table
`timescale 1ns / 1ps

package dhtab_pkg;

  // default geometry
  localparam int TABLE_SIZE_DEF   = 13;
  localparam int STEP_MODULUS_DEF = 11;

  // field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // key is reduced one digit per cycle, msb first
  localparam int DIG_W   = 4;
  localparam int KEY_CYC = (KEY_W + DIG_W - 1) / DIG_W;
  localparam int SRC_W   = KEY_CYC * DIG_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic hash;
    logic step_load;
    logic step_run;
    logic issue;
    logic eval;
    logic clear;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
  } sts_t;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_HASH    = 8'b0000_0100,
    S_STEP_LD = 8'b0000_1000,
    S_STEP    = 8'b0001_0000,
    S_PROBE   = 8'b0010_0000,
    S_DRAIN   = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } ctrl_state_t;

endpackage

>>> sv/dhtab_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module dhtab_ram #(
  parameter int WIDTH = dhtab_pkg::KEY_W + 1,
  parameter int DEPTH = dhtab_pkg::TABLE_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dhtab_dp.sv
// datapath: key reduction, probe address walk, slot memory and result registers
`timescale 1ns / 1ps

module dhtab_dp #(
  parameter int TABLE_SIZE   = dhtab_pkg::TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = dhtab_pkg::STEP_MODULUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhtab_pkg::in_beat_t  in_data,
  input  dhtab_pkg::cmd_t      cmd,
  output dhtab_pkg::sts_t      sts,
  output dhtab_pkg::out_beat_t out_data
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int SM_W   = $clog2(STEP_MODULUS);
  localparam int SV_W   = $clog2(STEP_MODULUS + 1);
  localparam int SB_CYC = (SV_W + dhtab_pkg::DIG_W - 1) / dhtab_pkg::DIG_W;
  localparam int ENT_W  = dhtab_pkg::KEY_W + 1;
  localparam int SRC_W  = dhtab_pkg::SRC_W;
  localparam int DIG_W  = dhtab_pkg::DIG_W;

  localparam logic [IDX_W:0]   T_EXT    = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [SM_W:0]    S_EXT    = (SM_W + 1)'(STEP_MODULUS);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_SIZE - 1);

  logic [dhtab_pkg::OP_W-1:0]  op_r,   op_nxt;
  logic [dhtab_pkg::KEY_W-1:0] key_r,  key_nxt;
  logic [SRC_W-1:0]            src_r,  src_nxt;
  logic [IDX_W-1:0]            home_r, home_nxt;
  logic [SM_W-1:0]             ms_r,   ms_nxt;
  logic [IDX_W-1:0]            step_r, step_nxt;
  logic [IDX_W-1:0]            pos_r,  pos_nxt;
  logic [IDX_W-1:0]            addr_d_r;
  logic                        rd_pend_r;
  dhtab_pkg::out_beat_t        res_r,  res_nxt;
  dhtab_pkg::out_beat_t        out_r,  out_nxt;

  logic [IDX_W:0]   h_w;
  logic [IDX_W-1:0] h_acc;
  logic [SM_W:0]    m_w;
  logic [SM_W-1:0]  m_acc;
  logic [IDX_W:0]   s_w;
  logic [IDX_W-1:0] s_acc;
  logic [IDX_W:0]   p_w;
  logic [IDX_W-1:0] pos_adv;
  logic [SV_W-1:0]  step_val;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic             ent_valid;
  logic             key_match;
  logic             hit;

  // one digit of restoring remainder for each running modulus
  always_comb begin
    h_acc = home_r;
    m_acc = ms_r;
    s_acc = step_r;
    h_w   = '0;
    m_w   = '0;
    s_w   = '0;
    for (int b = 0; b < DIG_W; b++) begin
      h_w = {h_acc, src_r[SRC_W-1-b]};
      if (h_w >= T_EXT) begin
        h_w = h_w - T_EXT;
      end
      h_acc = h_w[IDX_W-1:0];
      m_w = {m_acc, src_r[SRC_W-1-b]};
      if (m_w >= S_EXT) begin
        m_w = m_w - S_EXT;
      end
      m_acc = m_w[SM_W-1:0];
      s_w = {s_acc, src_r[SRC_W-1-b]};
      if (s_w >= T_EXT) begin
        s_w = s_w - T_EXT;
      end
      s_acc = s_w[IDX_W-1:0];
    end
  end

  // next probe position, modulo table size
  always_comb begin
    p_w = {1'b0, pos_r} + {1'b0, step_r};
    if (p_w >= T_EXT) begin
      p_w = p_w - T_EXT;
    end
    pos_adv = p_w[IDX_W-1:0];
  end

  assign step_val = SV_W'(ms_r) + SV_W'(1);

  // compare the entry read for the previous probe
  assign ent_valid = ram_rdata[ENT_W-1];
  assign key_match = ent_valid && (ram_rdata[ENT_W-2:0] == key_r);
  assign hit = cmd.eval && rd_pend_r &&
               (((op_r == dhtab_pkg::OP_INSERT) && !ent_valid) ||
                (((op_r == dhtab_pkg::OP_SEARCH) || (op_r == dhtab_pkg::OP_DELETE)) &&
                 key_match));

  assign sts.hit = hit;

  // slot memory writes: clearing pass, insert and delete
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_d_r;
    ram_wdata = '0;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
    end else if (hit && (op_r == dhtab_pkg::OP_INSERT)) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, key_r};
    end else if (hit && (op_r == dhtab_pkg::OP_DELETE)) begin
      ram_we    = 1'b1;
    end
  end

  dhtab_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // register next values
  always_comb begin
    op_nxt   = op_r;
    key_nxt  = key_r;
    src_nxt  = src_r;
    home_nxt = home_r;
    ms_nxt   = ms_r;
    step_nxt = step_r;
    pos_nxt  = pos_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    // capture the accepted beat, key zero-extended to whole digits
    if (cmd.start) begin
      op_nxt   = in_data.operation;
      key_nxt  = in_data.key;
      src_nxt  = SRC_W'(in_data.key);
      home_nxt = '0;
      ms_nxt   = '0;
      res_nxt.status = (in_data.operation == dhtab_pkg::OP_INSERT) ?
                       dhtab_pkg::ST_FULL : dhtab_pkg::ST_MISS;
      res_nxt.slot   = '0;
    end
    // key mod table size and key mod step modulus
    if (cmd.hash) begin
      src_nxt  = src_r << DIG_W;
      home_nxt = h_acc;
      ms_nxt   = m_acc;
    end
    // load the step for reduction and start the walk at home
    if (cmd.step_load) begin
      src_nxt  = SRC_W'(step_val) << (SRC_W - SB_CYC * DIG_W);
      step_nxt = '0;
      pos_nxt  = home_r;
    end
    if (cmd.step_run) begin
      src_nxt  = src_r << DIG_W;
      step_nxt = s_acc;
    end
    if (cmd.issue) begin
      pos_nxt = pos_adv;
    end
    // clearing pass walks every slot once
    if (cmd.clear) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + IDX_W'(1);
    end
    if (hit) begin
      res_nxt.status = dhtab_pkg::ST_OK;
      res_nxt.slot   = dhtab_pkg::SLOT_W'(addr_d_r);
    end
    if (cmd.out_load) begin
      out_nxt = res_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      rd_pend_r <= cmd.issue;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    src_r    <= src_nxt;
    home_r   <= home_nxt;
    ms_r     <= ms_nxt;
    step_r   <= step_nxt;
    addr_d_r <= pos_r;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

>>> sv/dhtab_ctrl.sv
// controller: sequences clearing, key reduction, probing and result handoff
`timescale 1ns / 1ps

module dhtab_ctrl #(
  parameter int TABLE_SIZE   = dhtab_pkg::TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = dhtab_pkg::STEP_MODULUS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output dhtab_pkg::cmd_t cmd,
  input  dhtab_pkg::sts_t sts
);

  localparam int SV_W    = $clog2(STEP_MODULUS + 1);
  localparam int SB_CYC  = (SV_W + dhtab_pkg::DIG_W - 1) / dhtab_pkg::DIG_W;
  localparam int CNT_TOP = (TABLE_SIZE > dhtab_pkg::KEY_CYC) ?
                           TABLE_SIZE : dhtab_pkg::KEY_CYC;
  localparam int CNT_W   = $clog2(CNT_TOP);

  localparam logic [CNT_W-1:0] CNT_TBL_LAST  = CNT_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_KEY_LAST  = CNT_W'(dhtab_pkg::KEY_CYC - 1);
  localparam logic [CNT_W-1:0] CNT_STEP_LAST = CNT_W'(SB_CYC - 1);

  dhtab_pkg::ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r,   cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // state machine
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      dhtab_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (cnt_r == CNT_TBL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = dhtab_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      dhtab_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = dhtab_pkg::S_HASH;
        end
      end
      dhtab_pkg::S_HASH: begin
        cmd.hash = 1'b1;
        if (cnt_r == CNT_KEY_LAST) begin
          cnt_nxt   = '0;
          state_nxt = dhtab_pkg::S_STEP_LD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      dhtab_pkg::S_STEP_LD: begin
        cmd.step_load = 1'b1;
        state_nxt     = dhtab_pkg::S_STEP;
      end
      dhtab_pkg::S_STEP: begin
        cmd.step_run = 1'b1;
        if (cnt_r == CNT_STEP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = dhtab_pkg::S_PROBE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      dhtab_pkg::S_PROBE: begin
        cmd.issue = 1'b1;
        cmd.eval  = 1'b1;
        if (sts.hit) begin
          state_nxt = dhtab_pkg::S_FINISH;
        end else if (cnt_r == CNT_TBL_LAST) begin
          state_nxt = dhtab_pkg::S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      dhtab_pkg::S_DRAIN: begin
        cmd.eval  = 1'b1;
        state_nxt = dhtab_pkg::S_FINISH;
      end
      dhtab_pkg::S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = dhtab_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dhtab_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhtab_pkg::S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != dhtab_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/double_hash_open_address_table.sv
// top level of the double hash open addressing table
//
//   channel  dir  handshake           beat
//   in_      in   in_valid/in_stall   operation, key
//   out_     out  out_valid/out_stall status, slot
//
// an item runs from accept through key reduction, step reduction, probing of up to TABLE_SIZE
// slots and result handoff; a search, insert or delete that hits early ends sooner.
// the time per item is set by the key reduction (four key bits a cycle) and the single read port
// of the slot memory, which gives one probe a cycle.
// after reset a clearing pass empties every slot, with in_stall high.
// a finished result waits in the output register; the next item is accepted meanwhile.
`timescale 1ns / 1ps

module double_hash_open_address_table #(
  parameter int TABLE_SIZE   = dhtab_pkg::TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = dhtab_pkg::STEP_MODULUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dhtab_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhtab_pkg::out_beat_t out_data
);

  dhtab_pkg::cmd_t cmd;
  dhtab_pkg::sts_t sts;

  // sequencer
  dhtab_ctrl #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hashing, probing and slot storage
  dhtab_dp #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> sv/dhtab_checker.sv
// port level checks of the double hash table, bound to the top level
`timescale 1ns / 1ps
`include "double_hash_open_address_table_defines.svh"

module dhtab_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input dhtab_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  `DHTAB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed under stall")

  // status is one of the defined codes
  `DHTAB_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, (out_data.status == dhtab_pkg::ST_OK) || (out_data.status == dhtab_pkg::ST_MISS) || (out_data.status == dhtab_pkg::ST_FULL), "undefined status code")

  // a miss or full answer carries slot zero
  `DHTAB_ASSERT_NOW(a_miss_slot, clk, rst_n, out_valid && (out_data.status != dhtab_pkg::ST_OK), out_data.slot == '0, "nonzero slot on miss or full")

  // one item at a time: busy right after an accepted beat
  `DHTAB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")

endmodule

bind double_hash_open_address_table dhtab_checker u_dhtab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
